// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ===== hdl/hpwl_pkg.sv =====
// ----------------------------------------------------------------------------
// HPWL package
// Widths, defaults and shared types of the wirelength totals block.
// ----------------------------------------------------------------------------
package hpwl_pkg;

  // Fixed widths of the word fields.
  localparam int PIN_W = 32;
  localparam int OUT_W = 48;

  // Defaults of the top-level parameters.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int TOTAL_WIDTH_DEF = 48;

  // Result buffer; the depth must be a power of two.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // Tag that travels beside a pin word through the pipeline.
  typedef struct packed {
    logic close;
    logic skipped;
    logic emit;
  } hpwl_ctl_t;

  typedef struct packed {
    logic [OUT_W-1:0] total_all;
    logic [OUT_W-1:0] total_limited;
    logic [OUT_W-1:0] total_without_pads;
    logic             saturated;
  } hpwl_res_t;

endpackage

// ===== hdl/hpwl_in_if.sv =====
// ----------------------------------------------------------------------------
// HPWL pin channel
// Valid/ready channel that carries one pin word per handshake.
// ----------------------------------------------------------------------------
interface hpwl_in_if import hpwl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    has_pin;
  logic signed [PIN_W-1:0] pin_x;
  logic signed [PIN_W-1:0] pin_y;
  logic                    pin_is_pad;
  logic                    net_skipped;
  logic                    last_in_net;
  logic                    last_net;

  modport source (
    output valid, has_pin, pin_x, pin_y, pin_is_pad, net_skipped, last_in_net, last_net,
    input  ready
  );

  modport sink (
    input  valid, has_pin, pin_x, pin_y, pin_is_pad, net_skipped, last_in_net, last_net,
    output ready
  );
endinterface

// ===== hdl/hpwl_out_if.sv =====
// ----------------------------------------------------------------------------
// HPWL totals channel
// Valid/ready channel that carries one totals word per handshake.
// ----------------------------------------------------------------------------
interface hpwl_out_if import hpwl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] total_all;
  logic [OUT_W-1:0] total_limited;
  logic [OUT_W-1:0] total_without_pads;
  logic             saturated;

  modport source (
    output valid, total_all, total_limited, total_without_pads, saturated,
    input  ready
  );

  modport sink (
    input  valid, total_all, total_limited, total_without_pads, saturated,
    output ready
  );
endinterface

// ===== hdl/hpwl_box.sv =====
// ----------------------------------------------------------------------------
// HPWL bounding box
// Grows one net bounding box per pin, snapshots it at net end and
// registers its half-perimeter from the snapshot in the following cycle.
// ----------------------------------------------------------------------------
module hpwl_box import hpwl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          grow,
  input  logic                          close,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  output logic        [COORD_WIDTH:0]   len
);

  logic signed [COORD_WIDTH-1:0] xmin, xmax, ymin, ymax;
  logic                          seen;
  logic signed [COORD_WIDTH-1:0] g_xmin, g_xmax, g_ymin, g_ymax;
  logic                          g_seen;
  logic signed [COORD_WIDTH-1:0] snap_xmin, snap_xmax, snap_ymin, snap_ymax;
  logic                          snap_seen;
  logic        [COORD_WIDTH-1:0] dx, dy;

  // The first pin of a net sets the box outright; later pins widen it.
  always_comb begin
    g_xmin = xmin;
    g_xmax = xmax;
    g_ymin = ymin;
    g_ymax = ymax;
    g_seen = seen;
    if (grow) begin
      g_seen = 1'b1;
      if (!seen) begin
        g_xmin = x;
        g_xmax = x;
        g_ymin = y;
        g_ymax = y;
      end else begin
        if (x < xmin) g_xmin = x;
        if (x > xmax) g_xmax = x;
        if (y < ymin) g_ymin = y;
        if (y > ymax) g_ymax = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      snap_seen <= 1'b0;
    end else begin
      seen <= close ? 1'b0 : g_seen;
      if (close) snap_seen <= g_seen;
    end
  end

  always_ff @(posedge clk) begin
    xmin <= g_xmin;
    xmax <= g_xmax;
    ymin <= g_ymin;
    ymax <= g_ymax;
    if (close) begin
      snap_xmin <= g_xmin;
      snap_xmax <= g_xmax;
      snap_ymin <= g_ymin;
      snap_ymax <= g_ymax;
    end
  end

  // Both spans are non-negative and below 2^COORD_WIDTH.
  assign dx = snap_xmax - snap_xmin;
  assign dy = snap_ymax - snap_ymin;

  always_ff @(posedge clk) begin
    len <= snap_seen ? ({1'b0, dx} + {1'b0, dy}) : '0;
  end

endmodule

// ===== hdl/hpwl_accum.sv =====
// ----------------------------------------------------------------------------
// HPWL accumulator
// Adds net lengths to three saturating totals and hands out the totals
// word at netlist end.
// ----------------------------------------------------------------------------
module hpwl_accum import hpwl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hpwl_ctl_t            ctl,
  input  logic [COORD_WIDTH:0] len_all,
  input  logic [COORD_WIDTH:0] len_core,
  output logic                 push,
  output hpwl_res_t            res
);

  localparam int WIDE_W = TOTAL_WIDTH + 1;
  localparam int EXT_W  = OUT_W + TOTAL_WIDTH;

  logic [TOTAL_WIDTH-1:0] sum_all, sum_limited, sum_core;
  logic                   overflow_seen;
  logic [COORD_WIDTH:0]   inc_all, inc_lim, inc_core;
  logic [WIDE_W-1:0]      w_all, w_lim, w_core;
  logic [TOTAL_WIDTH-1:0] sum_all_next, sum_limited_next, sum_core_next;
  logic                   overflow_seen_next;
  logic [EXT_W-1:0]       ext_all, ext_lim, ext_core;

  assign inc_all  = ctl.close ? len_all : '0;
  assign inc_lim  = (ctl.close && !ctl.skipped) ? len_all : '0;
  assign inc_core = ctl.close ? len_core : '0;

  // One spare bit catches the carry that means the total passed its maximum.
  assign w_all  = {1'b0, sum_all}     + WIDE_W'(inc_all);
  assign w_lim  = {1'b0, sum_limited} + WIDE_W'(inc_lim);
  assign w_core = {1'b0, sum_core}    + WIDE_W'(inc_core);

  assign sum_all_next     = w_all[TOTAL_WIDTH]  ? {TOTAL_WIDTH{1'b1}} : w_all[TOTAL_WIDTH-1:0];
  assign sum_limited_next = w_lim[TOTAL_WIDTH]  ? {TOTAL_WIDTH{1'b1}} : w_lim[TOTAL_WIDTH-1:0];
  assign sum_core_next    = w_core[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : w_core[TOTAL_WIDTH-1:0];
  assign overflow_seen_next = overflow_seen | w_all[TOTAL_WIDTH] | w_lim[TOTAL_WIDTH]
                            | w_core[TOTAL_WIDTH];

  assign ext_all  = {{OUT_W{1'b0}}, sum_all_next};
  assign ext_lim  = {{OUT_W{1'b0}}, sum_limited_next};
  assign ext_core = {{OUT_W{1'b0}}, sum_core_next};

  assign push                   = ctl.emit;
  assign res.total_all          = ext_all[OUT_W-1:0];
  assign res.total_limited      = ext_lim[OUT_W-1:0];
  assign res.total_without_pads = ext_core[OUT_W-1:0];
  assign res.saturated          = overflow_seen_next;

  always_ff @(posedge clk) begin
    if (rst || ctl.emit) begin
      sum_all       <= '0;
      sum_limited   <= '0;
      sum_core      <= '0;
      overflow_seen <= 1'b0;
    end else begin
      sum_all       <= sum_all_next;
      sum_limited   <= sum_limited_next;
      sum_core      <= sum_core_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ===== hdl/hpwl_out_fifo.sv =====
// ----------------------------------------------------------------------------
// HPWL result buffer
// Small register queue that holds finished totals words for the sink.
// ----------------------------------------------------------------------------
module hpwl_out_fifo import hpwl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hpwl_res_t push_data,
  hpwl_out_if.source totals
);

  hpwl_res_t         mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr, rd_ptr;
  logic [OUT_AW:0]   count;
  logic              pop;
  hpwl_res_t         head;

  assign pop  = totals.valid && totals.ready;
  assign head = mem[rd_ptr];

  assign totals.valid              = (count != '0);
  assign totals.total_all          = head.total_all;
  assign totals.total_limited      = head.total_limited;
  assign totals.total_without_pads = head.total_without_pads;
  assign totals.saturated          = head.saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (OUT_AW+1)'(push) - (OUT_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== hdl/half_perimeter_wirelength_totals_top.sv =====
// ----------------------------------------------------------------------------
// Half-perimeter wirelength totals
// Streams net pins, tracks all-pin and core-pin bounding boxes per net and
// emits saturating wirelength totals at the end of each netlist.
// ----------------------------------------------------------------------------
// The block takes one pin word per cycle while ready is high: the bounding
// boxes grow in the cycle a word is accepted, the half-perimeters are
// registered from the net-end snapshots, the totals are updated from them,
// and a totals word is pushed into the buffer once the word that carries
// last_net is accepted. Finished totals wait in an eight-entry buffer, and
// the pin side keeps flowing while the sink stalls; ready drops only when
// eight netlist-end words are in flight or waiting to be taken. A word with
// last_net also closes the open net, and the totals clear after each
// netlist-end word. Coordinates are taken from the low COORD_WIDTH bits as
// signed values, and each total is TOTAL_WIDTH bits wide, clamps at its
// maximum and raises saturated until the totals are next emitted.
// ----------------------------------------------------------------------------
module half_perimeter_wirelength_totals_top import hpwl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  hpwl_in_if.sink  pins,
  hpwl_out_if.source totals
);

  logic                          accept;
  logic                          grow_all, grow_core, close;
  logic signed [COORD_WIDTH-1:0] x, y;
  logic        [COORD_WIDTH:0]   len_all, len_core;
  hpwl_ctl_t                     st1, st2;
  logic                          push;
  hpwl_res_t                     res;
  logic        [OUT_AW:0]        pending;
  logic                          pop;

  // Netlist-end words still owed to the sink, counted from acceptance until
  // their totals word is taken. Capping it at the buffer depth means the
  // buffer can never overflow and the pipeline never has to stall.
  assign pins.ready = (pending < (OUT_AW+1)'(OUT_DEPTH));
  assign accept     = pins.valid && pins.ready;
  assign pop        = totals.valid && totals.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + (OUT_AW+1)'(accept && pins.last_net) - (OUT_AW+1)'(pop);
    end
  end

  // Bits above COORD_WIDTH are dropped; the rest is read as signed.
  assign x = $signed(pins.pin_x[COORD_WIDTH-1:0]);
  assign y = $signed(pins.pin_y[COORD_WIDTH-1:0]);

  assign grow_all  = accept && pins.has_pin;
  assign grow_core = grow_all && !pins.pin_is_pad;
  assign close     = accept && (pins.last_in_net || pins.last_net);

  // The tag follows the word through the box and length stages so that the
  // accumulator sees a net end exactly when that net's lengths arrive.
  always_ff @(posedge clk) begin
    if (rst) begin
      st1 <= '0;
      st2 <= '0;
    end else begin
      st1.close   <= close;
      st1.skipped <= pins.net_skipped;
      st1.emit    <= accept && pins.last_net;
      st2         <= st1;
    end
  end

  hpwl_box #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_box_all (
    .clk  (clk),
    .rst  (rst),
    .grow (grow_all),
    .close(close),
    .x    (x),
    .y    (y),
    .len  (len_all)
  );

  hpwl_box #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_box_core (
    .clk  (clk),
    .rst  (rst),
    .grow (grow_core),
    .close(close),
    .x    (x),
    .y    (y),
    .len  (len_core)
  );

  hpwl_accum #(
    .COORD_WIDTH(COORD_WIDTH),
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .ctl     (st2),
    .len_all (len_all),
    .len_core(len_core),
    .push    (push),
    .res     (res)
  );

  hpwl_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(res),
    .totals   (totals)
  );

endmodule

// ===== hdl/hpwl_check.sv =====
// ----------------------------------------------------------------------------
// HPWL port checker
// Watches the ports of the wirelength totals block over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpwl_check import hpwl_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last_net,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_total_all,
  input logic [OUT_W-1:0] out_total_limited,
  input logic [OUT_W-1:0] out_total_without_pads,
  input logic             out_saturated
);

  logic in_end;

  assign in_end = in_valid && in_ready && in_last_net;

  // A totals word that is not taken stays put.
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_total_all) && $stable(out_total_limited) && $stable(out_total_without_pads) && $stable(out_saturated))

  // Every netlist end shows up at the output once its totals word has passed the pipeline.
  `ASSERT_IMP(a_end_to_out, clk, rst, in_end, ##3 out_valid)

  // The output never turns valid without an earlier netlist end behind it.
  `ASSERT_IMP(a_out_has_cause, clk, rst, $rose(out_valid), $past(in_end, 3))

endmodule

bind half_perimeter_wirelength_totals_top hpwl_check u_hpwl_check (
  .clk                   (clk),
  .rst                   (rst),
  .in_valid              (pins.valid),
  .in_ready              (pins.ready),
  .in_last_net           (pins.last_net),
  .out_valid             (totals.valid),
  .out_ready             (totals.ready),
  .out_total_all         (totals.total_all),
  .out_total_limited     (totals.total_limited),
  .out_total_without_pads(totals.total_without_pads),
  .out_saturated         (totals.saturated)
);

// ===== test/half_perimeter_wirelength_totals_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Half-perimeter wirelength totals testbench
// Streams pin words into the totals block and checks every totals word
// against an in-bench prediction of the bounding boxes and clamped sums.
// ----------------------------------------------------------------------------
module half_perimeter_wirelength_totals_top_tb;
  import hpwl_pkg::*;

  // A totals word passes only the snapshot, length and buffer registers, so a
  // short settle window at the end is enough to catch any stray totals word.
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_WIDTH_DEF) - 64'd1;
  localparam logic [PIN_W-1:0] COORD_MIN = {1'b1, {(PIN_W-1){1'b0}}};
  localparam logic [PIN_W-1:0] COORD_MAX = {1'b0, {(PIN_W-1){1'b1}}};

  // How the pins of one random net are spread over the plane.
  typedef enum int {SPREAD_WIDE, SPREAD_CORNERS, SPREAD_LOCAL} spread_t;

  typedef struct packed {
    logic             has_pin;
    logic [PIN_W-1:0] pin_x;
    logic [PIN_W-1:0] pin_y;
    logic             pin_is_pad;
    logic             net_skipped;
    logic             last_in_net;
    logic             last_net;
  } pin_word_t;

  typedef struct {
    longint xmin;
    longint xmax;
    longint ymin;
    longint ymax;
    bit     seen;
  } net_box_t;

  logic clk;
  logic rst;

  hpwl_in_if  pins();
  hpwl_out_if totals();

  half_perimeter_wirelength_totals_top dut (
    .clk    (clk),
    .rst    (rst),
    .pins   (pins),
    .totals (totals)
  );

  // Words waiting for the driver, and totals words still owed by the block.
  pin_word_t words_to_send[$];
  hpwl_res_t totals_expected[$];

  // Predicted state: the open net's two boxes and the running totals.
  net_box_t        all_box;
  net_box_t        core_box;
  longint unsigned run_all;
  longint unsigned run_limited;
  longint unsigned run_core;
  bit              clamp_seen;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  counted_words;
  int  mismatch_count;
  int  quiet_cycles;
  logic word_taken;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic net_box_t empty_box();
    net_box_t b;
    b.xmin = 0;
    b.xmax = 0;
    b.ymin = 0;
    b.ymax = 0;
    b.seen = 1'b0;
    return b;
  endfunction

  // The first pin of a net pins the box to a point; later pins stretch it.
  function automatic net_box_t box_add(net_box_t b, longint x, longint y);
    net_box_t n;
    n = b;
    if (!b.seen) begin
      n.xmin = x;
      n.xmax = x;
      n.ymin = y;
      n.ymax = y;
      n.seen = 1'b1;
    end else begin
      if (x < n.xmin) n.xmin = x;
      if (x > n.xmax) n.xmax = x;
      if (y < n.ymin) n.ymin = y;
      if (y > n.ymax) n.ymax = y;
    end
    return n;
  endfunction

  // Width plus height; a box that never saw a pin contributes nothing.
  function automatic longint unsigned box_span(net_box_t b);
    if (!b.seen) return 0;
    return longint'(b.xmax - b.xmin) + longint'(b.ymax - b.ymin);
  endfunction

  // The spans stay below 2^34, so the 64-bit sum never wraps before the
  // compare against the total's maximum.
  task automatic add_clamped(inout longint unsigned acc, input longint unsigned amount);
    if (acc + amount > TOTAL_MAX) begin
      acc = TOTAL_MAX;
      clamp_seen = 1'b1;
    end else begin
      acc = acc + amount;
    end
  endtask

  task automatic predict_totals(input pin_word_t w);
    longint          x;
    longint          y;
    longint unsigned span_all;
    hpwl_res_t       r;
    x = longint'($signed(w.pin_x));
    y = longint'($signed(w.pin_y));
    if (w.has_pin) begin
      all_box = box_add(all_box, x, y);
      if (!w.pin_is_pad) core_box = box_add(core_box, x, y);
    end
    // A netlist end closes the open net even without its own net-end mark.
    if (w.last_in_net || w.last_net) begin
      span_all = box_span(all_box);
      add_clamped(run_all, span_all);
      if (!w.net_skipped) add_clamped(run_limited, span_all);
      add_clamped(run_core, box_span(core_box));
      all_box  = empty_box();
      core_box = empty_box();
    end
    if (w.last_net) begin
      r.total_all          = run_all[OUT_W-1:0];
      r.total_limited      = run_limited[OUT_W-1:0];
      r.total_without_pads = run_core[OUT_W-1:0];
      r.saturated          = clamp_seen;
      totals_expected.push_back(r);
      run_all     = 0;
      run_limited = 0;
      run_core    = 0;
      clamp_seen  = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Words that carry neither a pin nor a close mark change nothing in the
  // block, so they do not count toward the length of a phase.
  task automatic push_word(input bit has_pin, input logic [PIN_W-1:0] x, y,
                           input bit pad, skipped, close_net, close_list);
    pin_word_t w;
    w.has_pin     = has_pin;
    w.pin_x       = x;
    w.pin_y       = y;
    w.pin_is_pad  = pad;
    w.net_skipped = skipped;
    w.last_in_net = close_net;
    w.last_net    = close_list;
    words_to_send.push_back(w);
    if (has_pin || close_net || close_list) counted_words++;
  endtask

  function automatic logic [PIN_W-1:0] pick_coord(spread_t spread, logic [PIN_W-1:0] base);
    case (spread)
      SPREAD_WIDE: return $urandom;
      SPREAD_CORNERS: begin
        case ($urandom_range(0, 3))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return base + $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // One netlist of a few nets with random pins. Most netlists are well
  // formed; some end on a word that does not close its own net, some run on
  // into the next netlist, and pin-less filler words show up between pins.
  task automatic queue_random_netlist();
    int               net_total;
    int               pin_total;
    int               pick;
    bit               ends_list;
    bit               close_on_pin;
    bit               list_here;
    bit               net_mark;
    bit               skip;
    spread_t          spread;
    logic [PIN_W-1:0] base_x;
    logic [PIN_W-1:0] base_y;
    net_total = $urandom_range(1, 6);
    ends_list = ($urandom_range(0, 9) != 0);
    for (int n = 0; n < net_total; n++) begin
      pick = $urandom_range(0, 9);
      spread = (pick < 3) ? SPREAD_WIDE : (pick < 4) ? SPREAD_CORNERS : SPREAD_LOCAL;
      base_x = $urandom;
      base_y = $urandom;
      pin_total = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
      close_on_pin = (pin_total > 0) && ($urandom_range(0, 3) != 0);
      list_here = ends_list && (n == net_total - 1);
      net_mark = list_here ? ($urandom_range(0, 3) != 0) : 1'b1;
      skip = ($urandom_range(0, 2) == 0);
      for (int p = 0; p < pin_total; p++) begin
        if ($urandom_range(0, 9) == 0)
          push_word(1'b0, $urandom, $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, 1'b0);
        if (close_on_pin && p == pin_total - 1)
          push_word(1'b1, pick_coord(spread, base_x), pick_coord(spread, base_y),
                    $urandom_range(0, 3) == 0, skip, net_mark, list_here);
        else
          push_word(1'b1, pick_coord(spread, base_x), pick_coord(spread, base_y),
                    $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end
      if (!close_on_pin)
        push_word(1'b0, $urandom, $urandom, 1'($urandom_range(0, 1)), skip, net_mark,
                  list_here);
    end
  endtask

  task automatic queue_random_words(input int amount);
    int goal;
    goal = counted_words + amount;
    while (counted_words < goal) queue_random_netlist();
  endtask

  // The sender stops here until the driver is empty and every owed totals
  // word has been taken.
  task automatic hold_until_drained();
    while (words_to_send.size() != 0 || pins.valid || totals_expected.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the next pending word at the falling edge once the
  // previous one has been taken, with random gaps between words.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    pin_word_t w;
    if (rst === 1'b0) begin
      if (!pins.valid || word_taken) begin
        if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          w = words_to_send.pop_front();
          pins.valid       <= 1'b1;
          pins.has_pin     <= w.has_pin;
          pins.pin_x       <= w.pin_x;
          pins.pin_y       <= w.pin_y;
          pins.pin_is_pad  <= w.pin_is_pad;
          pins.net_skipped <= w.net_skipped;
          pins.last_in_net <= w.last_in_net;
          pins.last_net    <= w.last_net;
        end else begin
          pins.valid <= 1'b0;
        end
      end
    end
  end

  // The totals sink stalls at random at the falling edge.
  always @(negedge clk) begin
    if (rst !== 1'b0) totals.ready <= 1'b0;
    else totals.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge an accepted pin word feeds the prediction,
  // and an accepted totals word is compared with the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input hpwl_res_t want, input hpwl_res_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected all=%0d limited=%0d no_pads=%0d sat=%0b, got all=%0d limited=%0d no_pads=%0d sat=%0b",
               $realtime, what, want.total_all, want.total_limited, want.total_without_pads,
               want.saturated, got.total_all, got.total_limited, got.total_without_pads,
               got.saturated);
  endtask

  always @(posedge clk) begin
    pin_word_t w;
    hpwl_res_t got;
    hpwl_res_t want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= pins.valid && pins.ready;
      if (pins.valid && pins.ready) begin
        w.has_pin     = pins.has_pin;
        w.pin_x       = pins.pin_x;
        w.pin_y       = pins.pin_y;
        w.pin_is_pad  = pins.pin_is_pad;
        w.net_skipped = pins.net_skipped;
        w.last_in_net = pins.last_in_net;
        w.last_net    = pins.last_net;
        predict_totals(w);
      end
      if (totals.valid && totals.ready) begin
        got.total_all          = totals.total_all;
        got.total_limited      = totals.total_limited;
        got.total_without_pads = totals.total_without_pads;
        got.saturated          = totals.saturated;
        if (totals_expected.size() == 0) begin
          note_mismatch("totals word with none owed", '0, got);
        end else begin
          want = totals_expected.pop_front();
          if (got.total_all !== want.total_all ||
              got.total_limited !== want.total_limited ||
              got.total_without_pads !== want.total_without_pads ||
              got.saturated !== want.saturated)
            note_mismatch("totals mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if (rst || (pins.valid && pins.ready) || (totals.valid && totals.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    pins.valid       = 1'b0;
    pins.has_pin     = 1'b0;
    pins.pin_x       = '0;
    pins.pin_y       = '0;
    pins.pin_is_pad  = 1'b0;
    pins.net_skipped = 1'b0;
    pins.last_in_net = 1'b0;
    pins.last_net    = 1'b0;
    totals.ready     = 1'b0;
    word_taken       = 1'b0;
    all_box          = empty_box();
    core_box         = empty_box();
    run_all          = 0;
    run_limited      = 0;
    run_core         = 0;
    clamp_seen       = 1'b0;
    counted_words    = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 21;
    recv_idle_pct    = 81;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A net spanning the whole coordinate range on both axes.
    push_word(1'b1, COORD_MAX, COORD_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, COORD_MIN, COORD_MAX, 1'b0, 1'b0, 1'b1, 1'b0);
    // An empty net; its coordinates and pad bit must be ignored.
    push_word(1'b0, 32'hdead_beef, 32'h1234_5678, 1'b1, 1'b1, 1'b1, 1'b0);
    // A skipped net of pad pins only, so its core box stays empty.
    push_word(1'b1, -5, 7, 1'b1, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, 100, -3, 1'b1, 1'b1, 1'b1, 1'b0);
    // A mixed net with a pin-less word inside; the skip mark on an inner
    // word has no effect.
    push_word(1'b1, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0);
    push_word(1'b1, 1000, 1000, 1'b1, 1'b0, 1'b0, 1'b0);
    push_word(1'b0, COORD_MAX, COORD_MIN, 1'b0, 1'b1, 1'b0, 1'b0);
    push_word(1'b1, -1, -1, 1'b0, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, 3, 2, 1'b0, 1'b0, 1'b1, 1'b0);
    // The netlist ends on a pin word without its own net-end mark.
    push_word(1'b1, 10, 20, 1'b0, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, -10, -20, 1'b1, 1'b0, 1'b0, 1'b1);
    // An empty netlist right after a netlist end.
    push_word(1'b0, '1, '1, 1'b1, 1'b1, 1'b0, 1'b1);
    // One skipped single-pin net that closes both net and netlist.
    push_word(1'b1, 5, 5, 1'b0, 1'b1, 1'b1, 1'b1);
    // A single-pin net adds zero; then core corners around a far pad pin.
    push_word(1'b1, COORD_MIN, COORD_MAX, 1'b0, 1'b0, 1'b1, 1'b0);
    push_word(1'b1, '0, '1, 1'b0, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, COORD_MIN, COORD_MIN, 1'b1, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, '1, '0, 1'b0, 1'b0, 1'b1, 1'b1);
    hold_until_drained();

    // Sender mostly busy, sink mostly stalled: the result buffer fills.
    queue_random_words(200);
    hold_until_drained();

    // Sender mostly idle, sink mostly ready.
    send_idle_pct = 81;
    recv_idle_pct = 21;
    queue_random_words(200);
    hold_until_drained();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_words(200);
    hold_until_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
